// ----- rtl/pbnns_pkg.sv -----
// ----------------------------------------------------------------------------
// pbnns_pkg
// Shared constants, codes and transaction types for the pivot-bounded
// nearest-neighbour search block.
// ----------------------------------------------------------------------------
`default_nettype none

package pbnns_pkg;

	localparam int MAX_PROTOTYPES = 1024;
	localparam int MAX_BASES      = 16;
	localparam int DIST_WIDTH     = 32;

	localparam int IDX_W  = $clog2(MAX_PROTOTYPES);
	localparam int SLOT_W = $clog2(MAX_BASES);
	localparam int CNT_W  = IDX_W + 1;
	localparam int NB_W   = SLOT_W + 1;
	localparam int TBL_AW = SLOT_W + IDX_W;
	localparam int CFG_W  = 11;

	localparam logic [1:0] REQ_SET_PIVOT = 2'd0;
	localparam logic [1:0] REQ_TABLE     = 2'd1;
	localparam logic [1:0] REQ_QUERY     = 2'd2;
	localparam logic [1:0] REQ_REPLY     = 2'd3;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	localparam logic REG_NUM_PROTOTYPES = 1'b0;
	localparam logic REG_NUM_BASES      = 1'b1;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [SLOT_W-1:0]     slot;
		logic [IDX_W-1:0]      proto_index;
		logic [DIST_WIDTH-1:0] distance;
	} in_t;

	typedef struct packed {
		logic                  result_kind;
		logic [IDX_W-1:0]      request_index;
		logic [IDX_W-1:0]      best_index;
		logic [DIST_WIDTH-1:0] best_distance;
	} out_t;

endpackage

`default_nettype wire

// ----- rtl/pbnns_ram.sv -----
// ----------------------------------------------------------------------------
// pbnns_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pbnns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pivot_bounded_nearest_neighbour_search_top.sv -----
// ----------------------------------------------------------------------------
// pivot_bounded_nearest_neighbour_search_top
// LAESA nearest-neighbour search: pivot-distance bounds, smallest-bound
// candidate requests, stop when the bound exceeds the best distance.
// ----------------------------------------------------------------------------
//  Channel | Signals                       | Direction | Carries
//  in      | in_valid, in_stall, in_data   | sink      | load / query / reply
//  out     | out_valid, out_stall, out_data| source    | request or done
//  cfg     | cfg_we, cfg_index, cfg_data   | sink      | num_prototypes, num_bases
//
//  Load items and non-final query distances are accepted without raising in_stall.
//  Final query distance: bound computation over all 1024 prototype slots
//  (one table RAM read per pivot per prototype), then a scan.
//  Reply: a scan of num_prototypes lower-bound entries, one lower-bound RAM read per cycle.
//  After reset a clearing pass over all 1024 pivot flags holds in_stall.
//  A waiting result does not block loads; the next result waits for it with in_stall high.
// ----------------------------------------------------------------------------
`default_nettype none

module pivot_bounded_nearest_neighbour_search_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire pbnns_pkg::in_t        in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output pbnns_pkg::out_t            out_data,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [pbnns_pkg::CFG_W-1:0] cfg_data
);

	import pbnns_pkg::*;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_DEC   = 3'd5;

	localparam logic [DIST_WIDTH-1:0] DIST_ONES = '1;
	localparam logic [IDX_W-1:0]      IDX_LAST  = '1;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      num_protos_q;
	logic [NB_W-1:0]       num_bases_q;
	logic [SLOT_W-1:0]     i_q;
	logic [CNT_W-1:0]      j_q;
	logic [DIST_WIDTH-1:0] g_q;
	logic                  found_q;
	logic [IDX_W-1:0]      pick_q;
	logic [DIST_WIDTH-1:0] low_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [DIST_WIDTH-1:0] best_dist_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic                  active_q;
	logic [IDX_W-1:0]      pending_q;
	logic [IDX_W-1:0]      pivot_list_q [MAX_BASES];
	logic [DIST_WIDTH-1:0] qpd_q [MAX_BASES];
	logic                  out_valid_q;
	out_t                  out_q;

	logic [CNT_W-1:0]      np_eff;
	logic [NB_W-1:0]       nb_eff;
	logic [SLOT_W-1:0]     last_slot;
	logic                  accept;

	logic                  tbl_we;
	logic [TBL_AW-1:0]     tbl_waddr;
	logic                  tbl_re;
	logic [TBL_AW-1:0]     tbl_raddr;
	logic [DIST_WIDTH-1:0] tbl_rdata;

	logic                  flag_we;
	logic [IDX_W-1:0]      flag_waddr;
	logic                  flag_wdata;
	logic                  flag_re;
	logic                  flag_rdata;

	logic                  lb_we;
	logic [IDX_W-1:0]      lb_waddr;
	logic [DIST_WIDTH:0]   lb_wdata;
	logic                  lb_re;
	logic [DIST_WIDTH:0]   lb_rdata;

	logic [DIST_WIDTH-1:0] qa;
	logic [DIST_WIDTH-1:0] diff;
	logic [DIST_WIDTH-1:0] g_next;
	logic                  take;
	logic                  scan_better;

	always_comb begin
		np_eff = (num_protos_q > CNT_W'(MAX_PROTOTYPES)) ? CNT_W'(MAX_PROTOTYPES)
			: num_protos_q;
		if (num_bases_q == '0) begin
			nb_eff = NB_W'(1);
		end else if (num_bases_q > NB_W'(MAX_BASES)) begin
			nb_eff = NB_W'(MAX_BASES);
		end else begin
			nb_eff = num_bases_q;
		end
		last_slot = SLOT_W'(nb_eff - NB_W'(1));
	end

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// shared subtract / compare unit
	always_comb begin
		qa     = qpd_q[i_q];
		diff   = (qa > tbl_rdata) ? (qa - tbl_rdata) : (tbl_rdata - qa);
		g_next = (i_q == '0 || diff > g_q) ? diff : g_q;
	end

	assign take        = found_q && (low_q <= best_dist_q);
	assign scan_better = vld_s1 && !lb_rdata[DIST_WIDTH]
		&& (!found_q || lb_rdata[DIST_WIDTH-1:0] < low_q);

	always_comb begin
		tbl_we    = accept && in_data.req_type == REQ_TABLE;
		tbl_waddr = {in_data.slot, in_data.proto_index};
		tbl_re    = (state_q == ST_ISSUE);
		tbl_raddr = {i_q, j_q[IDX_W-1:0]};

		flag_we    = (state_q == ST_CLR) || (accept && in_data.req_type == REQ_SET_PIVOT);
		flag_waddr = (state_q == ST_CLR) ? j_q[IDX_W-1:0] : in_data.proto_index;
		flag_wdata = (state_q != ST_CLR);
		flag_re    = (state_q == ST_ISSUE);

		lb_re    = (state_q == ST_ISSUE) || (state_q == ST_SCAN && j_q < np_eff);
		lb_we    = 1'b0;
		lb_waddr = j_q[IDX_W-1:0];
		lb_wdata = {1'b1, low_q};
		if (state_q == ST_ACC && i_q == last_slot) begin
			lb_we    = 1'b1;
			lb_wdata = (j_q < np_eff) ? {flag_rdata, g_next}
				: {1'b0, lb_rdata[DIST_WIDTH-1:0]};
		end else if (state_q == ST_DEC && !out_valid_q && take) begin
			lb_we    = 1'b1;
			lb_waddr = pick_q;
		end
	end

	pbnns_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_BASES * MAX_PROTOTYPES)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (in_data.distance),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	pbnns_ram #(.WIDTH(1), .DEPTH(MAX_PROTOTYPES)) u_flag (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.re    (flag_re),
		.raddr (j_q[IDX_W-1:0]),
		.rdata (flag_rdata)
	);

	// {visited, lower bound}
	pbnns_ram #(.WIDTH(DIST_WIDTH + 1), .DEPTH(MAX_PROTOTYPES)) u_bound (
		.clk   (clk),
		.we    (lb_we),
		.waddr (lb_waddr),
		.wdata (lb_wdata),
		.re    (lb_re),
		.raddr (j_q[IDX_W-1:0]),
		.rdata (lb_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept && in_data.req_type == REQ_SET_PIVOT) begin
			pivot_list_q[in_data.slot] <= in_data.proto_index;
		end
		if (accept && in_data.req_type == REQ_QUERY && NB_W'(in_data.slot) < nb_eff) begin
			qpd_q[in_data.slot] <= in_data.distance;
		end
		if (state_q == ST_ACC) begin
			g_q <= g_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			num_protos_q <= CNT_W'(MAX_PROTOTYPES);
			num_bases_q  <= NB_W'(2);
			i_q          <= '0;
			j_q          <= '0;
			found_q      <= 1'b0;
			pick_q       <= '0;
			low_q        <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			best_dist_q  <= DIST_ONES;
			best_idx_q   <= '0;
			active_q     <= 1'b0;
			pending_q    <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NUM_PROTOTYPES) begin
					num_protos_q <= cfg_data[CNT_W-1:0];
				end else begin
					num_bases_q <= cfg_data[NB_W-1:0];
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					j_q <= j_q + CNT_W'(1);
					if (j_q[IDX_W-1:0] == IDX_LAST) begin
						j_q     <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && in_data.req_type == REQ_QUERY
							&& NB_W'(in_data.slot) < nb_eff) begin
						active_q <= 1'b0;
						if (in_data.slot == '0) begin
							best_dist_q <= in_data.distance;
							best_idx_q  <= (in_data.distance < DIST_ONES)
								? pivot_list_q[in_data.slot] : '0;
						end else if (in_data.distance < best_dist_q) begin
							best_dist_q <= in_data.distance;
							best_idx_q  <= pivot_list_q[in_data.slot];
						end
						if (in_data.slot == last_slot) begin
							i_q     <= '0;
							j_q     <= '0;
							state_q <= ST_ISSUE;
						end
					end else if (accept && in_data.req_type == REQ_REPLY && active_q) begin
						if (in_data.distance < best_dist_q) begin
							best_dist_q <= in_data.distance;
							best_idx_q  <= pending_q;
						end
						j_q     <= '0;
						found_q <= 1'b0;
						vld_s1  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_ISSUE;
					if (i_q == last_slot) begin
						i_q <= '0;
						j_q <= j_q + CNT_W'(1);
						if (j_q[IDX_W-1:0] == IDX_LAST) begin
							j_q     <= '0;
							found_q <= 1'b0;
							vld_s1  <= 1'b0;
							state_q <= ST_SCAN;
						end
					end else begin
						i_q <= i_q + SLOT_W'(1);
					end
				end
				ST_SCAN: begin
					if (scan_better) begin
						found_q <= 1'b1;
						pick_q  <= idx_s1;
						low_q   <= lb_rdata[DIST_WIDTH-1:0];
					end
					if (j_q < np_eff) begin
						j_q    <= j_q + CNT_W'(1);
						vld_s1 <= 1'b1;
						idx_s1 <= j_q[IDX_W-1:0];
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_DEC: begin
					if (!out_valid_q) begin
						out_valid_q         <= 1'b1;
						out_q.best_index    <= best_idx_q;
						out_q.best_distance <= best_dist_q;
						if (take) begin
							out_q.result_kind   <= KIND_REQUEST;
							out_q.request_index <= pick_q;
							active_q            <= 1'b1;
							pending_q           <= pick_q;
						end else begin
							out_q.result_kind   <= KIND_DONE;
							out_q.request_index <= '0;
							active_q            <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pbnns_checker.sv -----
// ----------------------------------------------------------------------------
// pbnns_checker
// Port-level assertions for the search block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbnns_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire pbnns_pkg::in_t        in_data,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire pbnns_pkg::out_t       out_data
);

	import pbnns_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_done_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_DONE |-> out_data.request_index == '0)
		else $error("finish transaction carries a request index");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall
		&& (in_data.req_type == REQ_SET_PIVOT || in_data.req_type == REQ_TABLE)
		|=> !$rose(out_valid))
		else $error("load transaction produced a result");

	a_load_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall
		&& (in_data.req_type == REQ_SET_PIVOT || in_data.req_type == REQ_TABLE)
		|=> !in_stall)
		else $error("load transaction took more than one cycle");

endmodule

bind pivot_bounded_nearest_neighbour_search_top pbnns_checker u_pbnns_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
